@@ rtl/ndpcp_pkg.sv @@
// ----------------------------------------------------------------------------
// ndpcp_pkg
// Shared constants and types of the NDP receive credit and pull pacer.
// ----------------------------------------------------------------------------
`default_nettype none

package ndpcp_pkg;

	localparam int MAX_MESSAGES = 128;
	localparam int SLOT_W       = $clog2(MAX_MESSAGES);
	localparam int TIME_W       = 48;
	localparam int DELAY_W      = 24;
	localparam int CRED_W       = 16;

	localparam logic [0:0] REG_INITIAL_CREDIT = 1'b0;
	localparam logic [0:0] REG_PACKET_TX_TIME = 1'b1;

	localparam logic [15:0] INITIAL_CREDIT_RST = 16'd10;
	localparam logic [15:0] PACKET_TX_TIME_RST = 16'd120;

	localparam logic [1:0] KIND_CTRL    = 2'd0;
	localparam logic [1:0] KIND_DELIVER = 2'd1;
	localparam logic [1:0] KIND_CREDIT  = 2'd2;

	localparam int FL_DATA = 0;
	localparam int FL_ACK  = 1;
	localparam int FL_NACK = 2;
	localparam int FL_PULL = 3;
	localparam int FL_CHOP = 4;

	typedef struct packed {
		logic due_en;
		logic commit_en;
	} pace_req_t;

	typedef struct packed {
		logic               late;
		logic [DELAY_W-1:0] delay;
	} pace_res_t;

endpackage

`default_nettype wire

@@ rtl/ndp_receive_credit_and_pull_pacer_unit.sv @@
// ----------------------------------------------------------------------------
// ndp_receive_credit_and_pull_pacer_unit
// Answers received NDP headers with paced ACK/NACK/PULL and transmit events.
// ----------------------------------------------------------------------------
// One header is taken at a time. After acceptance the slot's credit entry is
// read from the credit memory's registered port, and for a data header it is
// updated and written back together with the pacer's next pull slot (S_CRED);
// the hold time is then resolved (S_PACE), and the up to two result beats leave
// through a single output register (S_EMIT), one per cycle while out_stall is
// low. These steps are set by the read-modify-write of the credit memory and
// the pacer's 48-bit add, compare and subtract. in_stall is high until the
// block returns to idle. There is no clearing pass: a slot must see a
// new-message header before its credit is meaningful.
`default_nettype none

module ndp_receive_credit_and_pull_pacer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [4:0]  hdr_flags,
	input  wire logic [31:0] remote_ip,
	input  wire logic [15:0] remote_port,
	input  wire logic [15:0] local_port,
	input  wire logic [15:0] msg_tag,
	input  wire logic [15:0] msg_length,
	input  wire logic [15:0] packet_offset,
	input  wire logic [15:0] pull_in,
	input  wire logic [6:0]  slot_id,
	input  wire logic        new_message,
	input  wire logic [47:0] now_ns,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [2:0]       out_flags,
	output logic [31:0]      dest_ip,
	output logic [15:0]      src_port_out,
	output logic [15:0]      dst_port_out,
	output logic [15:0]      msg_tag_out,
	output logic [15:0]      msg_length_out,
	output logic [15:0]      offset_out,
	output logic [15:0]      pull_out,
	output logic [23:0]      send_delay,
	output logic             last
);
	import ndpcp_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CRED,
		S_PACE,
		S_EMIT
	} state_t;

	state_t state_q;

	logic [15:0] initial_credit_q;
	logic [15:0] packet_tx_time_q;

	logic [4:0]        flags_q;
	logic [31:0]       ip_q;
	logic [15:0]       rport_q;
	logic [15:0]       lport_q;
	logic [15:0]       tag_q;
	logic [15:0]       len_q;
	logic [15:0]       off_q;
	logic [15:0]       pin_q;
	logic [SLOT_W-1:0] slot_q;
	logic              fresh_q;
	logic [47:0]       now_q;

	logic [CRED_W-1:0] credit_q;
	logic              pull_q;
	logic [2:0]        pend_q;
	logic              absorb_q;
	logic [DELAY_W-1:0] delay_q;

	logic              in_accept;
	logic [SLOT_W-1:0] in_slot;
	logic [CRED_W-1:0] rd_credit;
	logic [CRED_W-1:0] new_credit;
	logic              mem_we;
	logic              is_data;
	logic              pull_now;
	logic [16:0]       reach;
	pace_req_t         preq;
	pace_res_t         pres;
	logic              emit_go;
	logic [2:0]        pick;
	logic [2:0]        pend_next;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign in_slot   = SLOT_W'(slot_id % MAX_MESSAGES);
	assign is_data   = flags_q[FL_DATA];

	// config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_credit_q <= INITIAL_CREDIT_RST;
			packet_tx_time_q <= PACKET_TX_TIME_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INITIAL_CREDIT: initial_credit_q <= cfg_data;
				REG_PACKET_TX_TIME: packet_tx_time_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (in_accept) begin
			flags_q <= hdr_flags;
			ip_q    <= remote_ip;
			rport_q <= remote_port;
			lport_q <= local_port;
			tag_q   <= msg_tag;
			len_q   <= msg_length;
			off_q   <= packet_offset;
			pin_q   <= pull_in;
			slot_q  <= in_slot;
			fresh_q <= new_message;
			now_q   <= now_ns;
		end
	end

	// credit update
	assign new_credit = (fresh_q ? initial_credit_q : rd_credit)
		+ {{(CRED_W-1){1'b0}}, !flags_q[FL_CHOP]};
	assign mem_we = (state_q == S_CRED) && is_data;
	assign reach  = {1'b0, off_q} + {1'b0, initial_credit_q};
	assign pull_now = is_data && (flags_q[FL_CHOP] || (reach <= {1'b0, len_q}));

	ndpcp_credit_mem u_mem (
		.clk     (clk),
		.rd_en   (in_accept),
		.rd_addr (in_slot),
		.rd_data (rd_credit),
		.wr_en   (mem_we),
		.wr_addr (slot_q),
		.wr_data (new_credit)
	);

	assign preq.due_en    = (state_q == S_CRED);
	assign preq.commit_en = (state_q == S_PACE) && pull_q;

	ndpcp_pacer u_pacer (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (preq),
		.tx_time (packet_tx_time_q),
		.now     (now_q),
		.res     (pres)
	);

	// result selection
	assign emit_go = (state_q == S_EMIT) && (!out_valid || !out_stall);
	always_comb begin
		if (pend_q[0]) begin
			pick = 3'b001;
		end else if (pend_q[1]) begin
			pick = 3'b010;
		end else begin
			pick = 3'b100;
		end
	end
	assign pend_next = pend_q & ~pick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pend_q    <= '0;
			pull_q    <= 1'b0;
			absorb_q  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (emit_go) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						state_q <= S_CRED;
					end
				end
				S_CRED: begin
					pull_q  <= pull_now;
					state_q <= S_PACE;
				end
				S_PACE: begin
					absorb_q <= pull_q && pres.late;
					if (is_data) begin
						pend_q[0] <= pull_q;
						pend_q[1] <= !flags_q[FL_CHOP] && !(pull_q && pres.late);
						pend_q[2] <= flags_q[FL_CHOP] && !(pull_q && pres.late);
					end else begin
						pend_q[0] <= flags_q[FL_ACK];
						pend_q[1] <= flags_q[FL_NACK] || flags_q[FL_PULL];
						pend_q[2] <= 1'b0;
					end
					if (is_data || flags_q[FL_ACK] || flags_q[FL_NACK]
						|| flags_q[FL_PULL]) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						pend_q <= pend_next;
						if (pend_next == 3'b000) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CRED) begin
			credit_q <= new_credit;
		end
		if (state_q == S_PACE) begin
			delay_q <= pres.delay;
		end
	end

	// output beat
	always_ff @(posedge clk) begin
		if (emit_go) begin
			last        <= (pend_next == 3'b000);
			msg_tag_out <= tag_q;
			send_delay  <= '0;
			if (is_data) begin
				kind           <= KIND_CTRL;
				dest_ip        <= ip_q;
				src_port_out   <= lport_q;
				dst_port_out   <= rport_q;
				msg_length_out <= len_q;
				offset_out     <= off_q;
				pull_out       <= credit_q;
				if (pick[0]) begin
					out_flags  <= {1'b1, absorb_q && flags_q[FL_CHOP],
						absorb_q && !flags_q[FL_CHOP]};
					send_delay <= delay_q;
				end else if (pick[1]) begin
					out_flags <= 3'b001;
				end else begin
					out_flags <= 3'b010;
				end
			end else begin
				dest_ip      <= '0;
				src_port_out <= '0;
				dst_port_out <= '0;
				if (pick[0]) begin
					kind           <= KIND_DELIVER;
					out_flags      <= 3'b001;
					msg_length_out <= len_q;
					offset_out     <= off_q;
					pull_out       <= '0;
				end else begin
					kind           <= KIND_CREDIT;
					out_flags      <= {flags_q[FL_PULL], flags_q[FL_NACK], 1'b0};
					msg_length_out <= '0;
					offset_out     <= flags_q[FL_NACK] ? off_q : 16'd0;
					pull_out       <= flags_q[FL_PULL] ? pin_q : 16'd0;
				end
			end
		end
	end

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (pend_q == 3'b000))
		else $error("results pending while idle");

	a_emit_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (pend_q != 3'b000))
		else $error("emit state with nothing to send");

	a_mem_wb: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (state_q == S_PACE))
		else $error("credit write-back outside update step");

	a_beat_stage: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> out_valid)
		else $error("selected result did not reach the output register");

endmodule

`default_nettype wire

@@ rtl/ndpcp_credit_mem.sv @@
// ----------------------------------------------------------------------------
// ndpcp_credit_mem
// Per-slot credit table, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ndpcp_credit_mem (
	input  wire logic                       clk,
	input  wire logic                       rd_en,
	input  wire logic [ndpcp_pkg::SLOT_W-1:0] rd_addr,
	output logic      [ndpcp_pkg::CRED_W-1:0] rd_data,
	input  wire logic                       wr_en,
	input  wire logic [ndpcp_pkg::SLOT_W-1:0] wr_addr,
	input  wire logic [ndpcp_pkg::CRED_W-1:0] wr_data
);
	import ndpcp_pkg::*;

	logic [CRED_W-1:0] credit_mem_q [MAX_MESSAGES];
	logic [CRED_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			credit_mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= credit_mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ rtl/ndpcp_pacer.sv @@
// ----------------------------------------------------------------------------
// ndpcp_pacer
// Pull pacer: next pull slot, hold time and last pull time.
// ----------------------------------------------------------------------------
`default_nettype none

module ndpcp_pacer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ndpcp_pkg::pace_req_t        req,
	input  wire logic [15:0]                 tx_time,
	input  wire logic [ndpcp_pkg::TIME_W-1:0] now,
	output ndpcp_pkg::pace_res_t             res
);
	import ndpcp_pkg::*;

	logic [TIME_W-1:0] last_time_q;
	logic              primed_q;
	logic [TIME_W-1:0] due_q;
	logic [TIME_W:0]   due_sum;
	logic [TIME_W-1:0] gap;
	logic              late;

	assign due_sum = {1'b0, last_time_q} + {{(TIME_W-15){1'b0}}, tx_time};

	always_ff @(posedge clk) begin
		if (req.due_en) begin
			due_q <= due_sum[TIME_W] ? {TIME_W{1'b1}} : due_sum[TIME_W-1:0];
		end
	end

	assign late = !primed_q || (now >= due_q);
	assign gap  = due_q - now;

	always_comb begin
		res.late = late;
		if (late) begin
			res.delay = '0;
		end else if (|gap[TIME_W-1:DELAY_W]) begin
			res.delay = {DELAY_W{1'b1}};
		end else begin
			res.delay = gap[DELAY_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_time_q <= '0;
			primed_q    <= 1'b0;
		end else if (req.commit_en) begin
			last_time_q <= late ? now : due_q;
			primed_q    <= 1'b1;
		end
	end

endmodule

`default_nettype wire
